// ===== hw/rtl/ketu_pkg.sv =====
package ketu_pkg;

    // table geometry default and output slot width
    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int SLOT_W            = 3;

    // built-in entry present after reset
    localparam logic [31:0] BUILTIN_KEY   = {8'hE2, 8'h80, 8'h11, 8'h05};
    localparam logic [15:0] BUILTIN_WORD  = 16'h0000;
    localparam logic [15:0] BUILTIN_MASK  = 16'h0100;
    localparam logic [15:0] BUILTIN_PAT_A = 16'h0000;
    localparam logic [15:0] BUILTIN_PAT_B = 16'h0100;

    localparam logic [15:0] MAX_WORD_RST  = 16'h00FF;

    // command codes
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_UPSERT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] model_key;
        logic [15:0] word_index;
        logic [15:0] bit_mask;
        logic [15:0] pattern_a;
        logic [15:0] pattern_b;
    } t_in_word;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       found_word;
        logic [15:0]       found_mask;
        logic [15:0]       found_pattern_a;
        logic [15:0]       found_pattern_b;
    } t_out_word;

    // one table entry as held in a cell
    typedef struct packed {
        logic [31:0] model_key;
        logic [15:0] word_index;
        logic [15:0] bit_mask;
        logic [15:0] pattern_a;
        logic [15:0] pattern_b;
    } t_entry;

    // search result rippling along the chain
    typedef struct packed {
        logic        hit;
        logic [15:0] word_index;
        logic [15:0] bit_mask;
        logic [15:0] pattern_a;
        logic [15:0] pattern_b;
    } t_find;

    // per-cell write control
    typedef struct packed {
        logic live;
        logic write;
        logic place;
        logic shift;
    } t_cell_ctl;

    localparam t_entry BUILTIN_ENTRY = '{
        model_key:  BUILTIN_KEY,
        word_index: BUILTIN_WORD,
        bit_mask:   BUILTIN_MASK,
        pattern_a:  BUILTIN_PAT_A,
        pattern_b:  BUILTIN_PAT_B
    };

endpackage

// ===== hw/rtl/ketu_if.sv =====
// request channel
interface ketu_req_if import ketu_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// response channel
interface ketu_rsp_if import ketu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// configuration write channel (max word index)
interface ketu_cfg_if ();
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ketu_cell.sv =====
module ketu_cell import ketu_pkg::*; #(
    parameter int IDX_W = 3,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_new,
    input  t_entry           i_next,
    input  t_find            i_find,
    input  logic [IDX_W-1:0] i_slot,
    output t_entry           o_entry,
    output t_find            o_find,
    output logic [IDX_W-1:0] o_slot
);

    t_entry r_entry;
    logic   w_match;
    logic   w_first;
    logic   w_load;

    // compare against the request key; first hit along the chain wins
    assign w_match = i_ctl.live && (r_entry.model_key == i_new.model_key);
    assign w_first = w_match && !i_find.hit;
    assign w_load  = (i_ctl.write && w_first) || i_ctl.place;

    always_comb begin
        if (w_first) begin
            o_find.hit        = 1'b1;
            o_find.word_index = r_entry.word_index;
            o_find.bit_mask   = r_entry.bit_mask;
            o_find.pattern_a  = r_entry.pattern_a;
            o_find.pattern_b  = r_entry.pattern_b;
            o_slot            = IDX_W'(IDX);
        end else begin
            o_find = i_find;
            o_slot = i_slot;
        end
    end

    // entry store: overwrite, or take the neighbour's entry on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= BUILTIN_ENTRY;
        end else if (w_load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/keyed_entry_table_upsert_lookup_unit.sv =====
// Keyed entry table: lookup and insert/update of entries keyed by a 32-bit model id.
// Channels: i_req carries one command word (kind, key, entry contents); o_rsp returns
// exactly one result word per command; i_cfg writes max_word_index and is always ready.
// Write the register only while no command is in flight.
// Storage is a row of cells, one entry each. Every cell compares its key with the
// request in parallel and the first hit ripples down the row; on a full-table append
// each cell takes its upper neighbour's entry and the last cell takes the new one.
// A command is accepted in the idle state and registered; in the execute state the
// cell row works on it and its result word is registered once the output register is
// free, which raises o_rsp.valid. The next command is taken only after that step.
// If o_rsp is stalled, the next command is still accepted but waits in the execute
// state until the held result is taken; nothing is dropped.
// Reset (synchronous, active low) leaves one built-in entry in slot 0, an entry
// count of one and max_word_index at 255. No clearing pass is needed.
module keyed_entry_table_upsert_lookup_unit import ketu_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ketu_req_if.sink   i_req,
    ketu_rsp_if.source o_rsp,
    ketu_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    t_state            r_state;
    t_in_word          r_req;
    logic [CNT_W-1:0]  r_count;
    logic [15:0]       r_max_word;
    logic              r_out_valid;
    t_out_word         r_out;

    t_find             w_find [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  w_slot [0:TABLE_ENTRIES];
    t_entry            w_ent  [0:TABLE_ENTRIES];
    t_entry            w_new;

    logic              w_out_free;
    logic              w_exec;
    logic              w_key_ok;
    logic              w_chk;
    logic              w_full;
    logic              w_write;
    logic              w_append;
    logic              w_shift;
    logic [IDX_W-1:0]  w_slot_sel;
    logic [IDX_W+SLOT_W-1:0] w_slot_ext;
    t_out_word         n_out;

    // ---------------------------------------------------------------- handshakes
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_exec     = (r_state == ST_EXEC) && w_out_free;

    // ---------------------------------------------------------------- checks
    assign w_key_ok = (r_req.model_key != '0) && (r_req.model_key != '1);
    assign w_chk    = w_key_ok
                   && (r_req.word_index <= r_max_word)
                   && (r_req.bit_mask != '0)
                   && ((r_req.pattern_a & ~r_req.bit_mask) == '0)
                   && ((r_req.pattern_b & ~r_req.bit_mask) == '0)
                   && (r_req.pattern_a != r_req.pattern_b);

    assign w_full   = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_write  = w_exec && (r_req.kind == KIND_UPSERT) && w_chk;
    assign w_append = w_write && !w_find[TABLE_ENTRIES].hit && !w_full;
    assign w_shift  = w_write && !w_find[TABLE_ENTRIES].hit && w_full;

    assign w_new.model_key  = r_req.model_key;
    assign w_new.word_index = r_req.word_index;
    assign w_new.bit_mask   = r_req.bit_mask;
    assign w_new.pattern_a  = r_req.pattern_a;
    assign w_new.pattern_b  = r_req.pattern_b;

    // ---------------------------------------------------------------- cell row
    assign w_find[0]             = '0;
    assign w_slot[0]             = '0;
    assign w_ent[TABLE_ENTRIES]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.live  = (CNT_W'(g) < r_count);
        assign w_ctl.write = w_write;
        assign w_ctl.place = (w_append && (r_count == CNT_W'(g)))
                          || (w_shift && (g == TABLE_ENTRIES - 1));
        assign w_ctl.shift = w_shift;

        ketu_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_next  (w_ent[g+1]),
            .i_find  (w_find[g]),
            .i_slot  (w_slot[g]),
            .o_entry (w_ent[g]),
            .o_find  (w_find[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    // ---------------------------------------------------------------- result word
    always_comb begin
        if (r_req.kind == KIND_LOOKUP) begin
            w_slot_sel = w_slot[TABLE_ENTRIES];
        end else if (w_find[TABLE_ENTRIES].hit) begin
            w_slot_sel = w_slot[TABLE_ENTRIES];
        end else if (!w_full) begin
            w_slot_sel = r_count[IDX_W-1:0];
        end else begin
            w_slot_sel = IDX_W'(TABLE_ENTRIES - 1);
        end
    end

    assign w_slot_ext = {SLOT_W'(0), w_slot_sel};

    always_comb begin
        n_out = '0;
        if (r_req.kind == KIND_LOOKUP) begin
            if (w_key_ok && w_find[TABLE_ENTRIES].hit) begin
                n_out.ok              = 1'b1;
                n_out.slot            = w_slot_ext[SLOT_W-1:0];
                n_out.found_word      = w_find[TABLE_ENTRIES].word_index;
                n_out.found_mask      = w_find[TABLE_ENTRIES].bit_mask;
                n_out.found_pattern_a = w_find[TABLE_ENTRIES].pattern_a;
                n_out.found_pattern_b = w_find[TABLE_ENTRIES].pattern_b;
            end
        end else if (w_chk) begin
            n_out.ok   = 1'b1;
            n_out.slot = w_slot_ext[SLOT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result words
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    // entry count and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CNT_W'(1);
            r_max_word <= MAX_WORD_RST;
        end else begin
            if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_word <= i_cfg.data;
            end
        end
    end

endmodule

// ===== dv/tb_keyed_entry_table_upsert_lookup_unit.sv =====
`timescale 1ns / 100ps

import ketu_pkg::*;

// Shadow copy of the entry table: predicts one result word per command word
class entry_table_scoreboard;
    t_entry      slots[TABLE_ENTRIES_DEF];
    int unsigned used;
    logic [15:0] word_limit;
    t_out_word   pending_results[$];
    int unsigned mismatches;

    function new();
        foreach (slots[i]) slots[i] = '0;
        slots[0]   = BUILTIN_ENTRY;
        used       = 1;
        word_limit = MAX_WORD_RST;
        mismatches = 0;
    endfunction

    // first live slot holding the key, -1 when absent
    function int find_slot(logic [31:0] key);
        for (int i = 0; i < used; i++) begin
            if (slots[i].model_key == key) return i;
        end
        return -1;
    endfunction

    // work out the result of one accepted command word and update the table
    function void note_command(t_in_word cmd);
        t_out_word res;
        int        s;
        bit        key_ok;
        res    = '0;
        key_ok = (cmd.model_key != 32'h0) && (cmd.model_key != 32'hFFFF_FFFF);
        if (cmd.kind == KIND_LOOKUP) begin
            s = key_ok ? find_slot(cmd.model_key) : -1;
            if (s >= 0) begin
                res.ok              = 1'b1;
                res.slot            = s[SLOT_W-1:0];
                res.found_word      = slots[s].word_index;
                res.found_mask      = slots[s].bit_mask;
                res.found_pattern_a = slots[s].pattern_a;
                res.found_pattern_b = slots[s].pattern_b;
            end
        end else if (key_ok && cmd.word_index <= word_limit && cmd.bit_mask != 16'h0
                     && (cmd.pattern_a & ~cmd.bit_mask) == 16'h0
                     && (cmd.pattern_b & ~cmd.bit_mask) == 16'h0
                     && cmd.pattern_a != cmd.pattern_b) begin
            s = find_slot(cmd.model_key);
            if (s < 0) begin
                if (used < TABLE_ENTRIES_DEF) begin
                    s = used;
                    used++;
                end else begin
                    // full: oldest entry drops out of slot 0
                    for (int i = 0; i < TABLE_ENTRIES_DEF - 1; i++) slots[i] = slots[i + 1];
                    s = TABLE_ENTRIES_DEF - 1;
                end
            end
            slots[s].model_key  = cmd.model_key;
            slots[s].word_index = cmd.word_index;
            slots[s].bit_mask   = cmd.bit_mask;
            slots[s].pattern_a  = cmd.pattern_a;
            slots[s].pattern_b  = cmd.pattern_b;
            res.ok   = 1'b1;
            res.slot = s[SLOT_W-1:0];
        end
        pending_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // compare a result word with the oldest prediction
    function void check_result(t_out_word got);
        t_out_word want;
        if (pending_results.size() == 0) begin
            $error("result word with no prediction waiting: %0h", got);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("ok", 32'(want.ok), 32'(got.ok));
        compare_field("slot", 32'(want.slot), 32'(got.slot));
        compare_field("found_word", 32'(want.found_word), 32'(got.found_word));
        compare_field("found_mask", 32'(want.found_mask), 32'(got.found_mask));
        compare_field("found_pattern_a", 32'(want.found_pattern_a),
                      32'(got.found_pattern_a));
        compare_field("found_pattern_b", 32'(want.found_pattern_b),
                      32'(got.found_pattern_b));
    endfunction
endclass

module tb_keyed_entry_table_upsert_lookup_unit;

    localparam int POOL_SIZE   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 260;

    logic i_clk;
    logic i_rst_n;

    ketu_req_if req_ch ();
    ketu_rsp_if rsp_ch ();
    ketu_cfg_if cfg_ch ();

    entry_table_scoreboard sb = new();

    logic [31:0] key_pool[POOL_SIZE];
    bit          req_idle_on  = 1'b1;
    bit          rsp_idle_on  = 1'b1;
    bit          rsp_hold_req = 1'b0;

    keyed_entry_table_upsert_lookup_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("keyed_entry_table_upsert_lookup_unit verification failed");
        $finish;
    end

    // wait before the next word: often none, otherwise drawn at random
    function automatic int draw_wait(bit enabled);
        if (!enabled || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic t_in_word build_cmd(logic kind, logic [31:0] key, logic [15:0] w,
                                           logic [15:0] m, logic [15:0] a, logic [15:0] b);
        t_in_word c;
        c.kind       = kind;
        c.model_key  = key;
        c.word_index = w;
        c.bit_mask   = m;
        c.pattern_a  = a;
        c.pattern_b  = b;
        return c;
    endfunction

    // mostly well-formed commands on a small key set, with some broken ones
    function automatic t_in_word make_command();
        t_in_word c;
        int       r;
        c.kind = ($urandom_range(0, 9) < 4) ? KIND_LOOKUP : KIND_UPSERT;
        r = $urandom_range(0, 99);
        if (r < 70)      c.model_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 82) c.model_key = $urandom;
        else if (r < 88) c.model_key = 32'h0;
        else if (r < 94) c.model_key = 32'hFFFF_FFFF;
        else             c.model_key = BUILTIN_KEY;
        c.word_index = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, sb.word_limit));
        c.bit_mask  = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 16'hFFFF));
        c.pattern_a = 16'($urandom) & c.bit_mask;
        c.pattern_b = 16'($urandom) & c.bit_mask;
        // keep the patterns apart by flipping the lowest mask bit
        if (c.pattern_a == c.pattern_b)
            c.pattern_b ^= c.bit_mask & (~c.bit_mask + 16'd1);
        case ($urandom_range(0, 11))
            0:       c.pattern_a |= ~c.bit_mask & 16'($urandom);
            1:       c.pattern_b |= ~c.bit_mask & 16'($urandom);
            2:       c.pattern_b = c.pattern_a;
            default: ;
        endcase
        if (c.kind == KIND_LOOKUP && $urandom_range(0, 1) == 1) begin
            c.word_index = 16'($urandom);
            c.bit_mask   = 16'($urandom);
            c.pattern_a  = 16'($urandom);
            c.pattern_b  = 16'($urandom);
        end
        return c;
    endfunction

    // offer one command word; valid stays high if the next follows at once
    task automatic push_command(input t_in_word cmd);
        int gap;
        gap = draw_wait(req_idle_on);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= cmd;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_command(cmd);
    endtask

    // stop offering and let every predicted result come back
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_word_limit(input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.word_limit = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // short directed run against the reset limit of 255
    task automatic run_directed();
        push_command(build_cmd(KIND_LOOKUP, BUILTIN_KEY, 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_LOOKUP, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_command(build_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_LOOKUP, key_pool[1], 16'h0, 16'h0, 16'h0, 16'h0));
        // refused upserts, one reason each where possible
        push_command(build_cmd(KIND_UPSERT, 32'h0, 16'h0, 16'h0001, 16'h0001, 16'h0));
        push_command(build_cmd(KIND_UPSERT, 32'hFFFF_FFFF, 16'h0, 16'h0001, 16'h0001, 16'h0));
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'd256, 16'h00F0, 16'h0010,
                               16'h0020));
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'h0, 16'h00F0, 16'h0100,
                               16'h0010));
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'h0, 16'h00F0, 16'h0010,
                               16'h8000));
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'h0, 16'h00F0, 16'h0030,
                               16'h0030));
        // append at the limit, then update the built-in entry in place
        push_command(build_cmd(KIND_UPSERT, key_pool[1], 16'd255, 16'hFFFF, 16'hFFFF,
                               16'h0000));
        push_command(build_cmd(KIND_UPSERT, BUILTIN_KEY, 16'h0, 16'h8001, 16'h8000, 16'h0001));
        push_command(build_cmd(KIND_LOOKUP, BUILTIN_KEY, 16'h0, 16'h0, 16'h0, 16'h0));
        // fill the table, the last one pushes the oldest out
        for (int i = 2; i <= 8; i++)
            push_command(build_cmd(KIND_UPSERT, key_pool[i], 16'($urandom_range(0, 255)),
                                   16'h0FF0, 16'h0A50, 16'h05A0));
        push_command(build_cmd(KIND_LOOKUP, BUILTIN_KEY, 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_LOOKUP, key_pool[8], 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_LOOKUP, key_pool[1], 16'h0, 16'h0, 16'h0, 16'h0));
        push_command(build_cmd(KIND_LOOKUP, key_pool[2], 16'h0, 16'h0, 16'h0, 16'h0));
    endtask

    // result side: random stalls, one long hold on request
    initial begin : result_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rsp_hold_req) begin
                stall        = HOLD_CYCLES;
                rsp_hold_req = 1'b0;
            end else begin
                stall = draw_wait(rsp_idle_on);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            sb.check_result(rsp_ch.data);
        end
    end

    // main sequence
    initial begin : stimulus
        logic [15:0] limits[PHASES];
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        foreach (key_pool[i]) begin
            do key_pool[i] = $urandom;
            while (key_pool[i] == 32'h0 || key_pool[i] == 32'hFFFF_FFFF
                   || key_pool[i] == BUILTIN_KEY);
        end
        limits[0] = 16'hFFFF;
        limits[1] = 16'h0000;
        limits[2] = 16'($urandom_range(1, 16'hFFFE));
        limits[3] = MAX_WORD_RST;
        limits[4] = 16'($urandom_range(0, 15));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_results();
            write_word_limit(limits[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // phase 2 runs flat out; phase 1 floods the block while results are held
                req_idle_on = !(ph == 2 || (ph == 1 && n >= 40 && n < 120));
                rsp_idle_on = (ph != 2);
                if (ph == 1 && n == 40) rsp_hold_req = 1'b1;
                if (ph == 1 && n == 180) wait_for_results();
                push_command(make_command());
            end
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            $error("%0d predicted results never arrived", sb.pending_results.size());
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("keyed_entry_table_upsert_lookup_unit verification clean");
        end else begin
            $display("keyed_entry_table_upsert_lookup_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ketu_pkg.sv
hw/rtl/ketu_if.sv
hw/rtl/ketu_cell.sv
hw/rtl/keyed_entry_table_upsert_lookup_unit.sv
dv/tb_keyed_entry_table_upsert_lookup_unit.sv
